>>> src/obb_pkg.sv
// Shared types and constants for the oriented box overlap tester.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package obb_pkg;

   localparam int FIELD_BITS = 48;
   localparam int NUM_FIELDS = 10;
   localparam int NUM_AXES   = 15;

   typedef logic [FIELD_BITS-1:0] field_type;

   // position of each request field in the packed field array
   localparam int F_A_CENTER    = 0;
   localparam int F_A_AXIS_ONE  = 1;
   localparam int F_A_HALF_SIZE = 4;
   localparam int F_B_CENTER    = 5;
   localparam int F_B_AXIS_ONE  = 6;
   localparam int F_B_HALF_SIZE = 9;

   // cyclic component neighbors for the cross product
   localparam int NEXT_ONE [3] = '{1, 2, 0};
   localparam int NEXT_TWO [3] = '{2, 0, 1};

   // the two box axes other than a given one
   localparam int OTHER [3][2] = '{'{1, 2}, '{0, 2}, '{0, 1}};

endpackage
`default_nettype wire

>>> src/obb_req_if.sv
// Request and response channel interfaces of the overlap tester.
// Depends on obb_pkg for the field type.
`default_nettype none
interface obb_req_if;
   import obb_pkg::*;
   logic      valid;
   logic      ready;
   field_type a_center;
   field_type a_axis_one;
   field_type a_axis_two;
   field_type a_axis_three;
   field_type a_half_size;
   field_type b_center;
   field_type b_axis_one;
   field_type b_axis_two;
   field_type b_axis_three;
   field_type b_half_size;

   modport source (output valid, a_center, a_axis_one, a_axis_two, a_axis_three,
                   a_half_size, b_center, b_axis_one, b_axis_two, b_axis_three,
                   b_half_size, input ready);
   modport sink (input valid, a_center, a_axis_one, a_axis_two, a_axis_three,
                 a_half_size, b_center, b_axis_one, b_axis_two, b_axis_three,
                 b_half_size, output ready);
endinterface

interface obb_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

>>> src/obb_prep.sv
// Stage one: unpack both boxes, center difference, nine cross axes and
// the axis dot matrix. Depends on obb_pkg.
`default_nettype none
module obb_prep #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  obb_pkg::field_type              fields [obb_pkg::NUM_FIELDS],
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [COMPONENT_BITS:0]   d      [3],
   output logic signed [COMPONENT_BITS-1:0] ua     [3][3],
   output logic signed [COMPONENT_BITS-1:0] vb     [3][3],
   output logic [COMPONENT_BITS-1:0]        ha     [3],
   output logic [COMPONENT_BITS-1:0]        hb     [3],
   output logic signed [2*COMPONENT_BITS:0] cr     [9][3],
   output logic signed [2*COMPONENT_BITS+1:0] rm   [3][3]
);
   import obb_pkg::*;

   localparam int C  = COMPONENT_BITS;
   localparam int CW = 2*C + 1;
   localparam int RW = 2*C + 2;

   logic [3*C-1:0]        ext   [NUM_FIELDS];
   logic signed [C-1:0]   ca_w  [3];
   logic signed [C-1:0]   cb_w  [3];
   logic signed [C-1:0]   ua_w  [3][3];
   logic signed [C-1:0]   vb_w  [3][3];
   logic [C-1:0]          ha_w  [3];
   logic [C-1:0]          hb_w  [3];
   logic signed [C:0]     d_w   [3];
   logic signed [CW-1:0]  cr_w  [9][3];
   logic signed [RW-1:0]  rm_w  [3][3];

   logic                  valid_ff;
   logic signed [C:0]     d_ff  [3];
   logic signed [C-1:0]   ua_ff [3][3];
   logic signed [C-1:0]   vb_ff [3][3];
   logic [C-1:0]          ha_ff [3];
   logic [C-1:0]          hb_ff [3];
   logic signed [CW-1:0]  cr_ff [9][3];
   logic signed [RW-1:0]  rm_ff [3][3];

   always_comb begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         ext[f] = (3*C)'(fields[f]);
      end
      for (int k = 0; k < 3; k++) begin
         ca_w[k] = $signed(ext[F_A_CENTER][k*C +: C]);
         cb_w[k] = $signed(ext[F_B_CENTER][k*C +: C]);
         ha_w[k] = ext[F_A_HALF_SIZE][k*C +: C];
         hb_w[k] = ext[F_B_HALF_SIZE][k*C +: C];
         d_w[k]  = (C+1)'(ca_w[k]) - (C+1)'(cb_w[k]);
         for (int i = 0; i < 3; i++) begin
            ua_w[i][k] = $signed(ext[F_A_AXIS_ONE+i][k*C +: C]);
            vb_w[i][k] = $signed(ext[F_B_AXIS_ONE+i][k*C +: C]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               cr_w[i*3+j][k] = CW'(ua_w[i][NEXT_ONE[k]]) * CW'(vb_w[j][NEXT_TWO[k]])
                              - CW'(ua_w[i][NEXT_TWO[k]]) * CW'(vb_w[j][NEXT_ONE[k]]);
            end
            rm_w[i][j] = RW'(ua_w[i][0]) * RW'(vb_w[j][0])
                       + RW'(ua_w[i][1]) * RW'(vb_w[j][1])
                       + RW'(ua_w[i][2]) * RW'(vb_w[j][2]);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         d_ff  <= d_w;
         ua_ff <= ua_w;
         vb_ff <= vb_w;
         ha_ff <= ha_w;
         hb_ff <= hb_w;
         cr_ff <= cr_w;
         rm_ff <= rm_w;
      end
   end

   assign out_valid = valid_ff;
   assign d  = d_ff;
   assign ua = ua_ff;
   assign vb = vb_ff;
   assign ha = ha_ff;
   assign hb = hb_ff;
   assign cr = cr_ff;
   assign rm = rm_ff;
endmodule
`default_nettype wire

>>> src/obb_proj.sv
// Stage two: absolute projections of the center difference and of the
// cross axes onto the box axes. Depends on obb_pkg.
`default_nettype none
module obb_proj #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [COMPONENT_BITS:0]     d    [3],
   input  logic signed [COMPONENT_BITS-1:0]   ua   [3][3],
   input  logic signed [COMPONENT_BITS-1:0]   vb   [3][3],
   input  logic [COMPONENT_BITS-1:0]          ha_i [3],
   input  logic [COMPONENT_BITS-1:0]          hb_i [3],
   input  logic signed [2*COMPONENT_BITS:0]   cr   [9][3],
   input  logic signed [2*COMPONENT_BITS+1:0] rm   [3][3],
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [2*COMPONENT_BITS:0]         la   [3],
   output logic [2*COMPONENT_BITS:0]         lb   [3],
   output logic [3*COMPONENT_BITS+1:0]       lc   [9],
   output logic [3*COMPONENT_BITS:0]         pa   [9][2],
   output logic [3*COMPONENT_BITS:0]         pb   [9][2],
   output logic [2*COMPONENT_BITS:0]         rabs [3][3],
   output logic [COMPONENT_BITS-1:0]         ha_o [3],
   output logic [COMPONENT_BITS-1:0]         hb_o [3]
);
   import obb_pkg::*;

   localparam int C  = COMPONENT_BITS;
   localparam int LW = 2*C + 2;
   localparam int XW = 3*C + 3;
   localparam int PW = 3*C + 2;
   localparam int RW = 2*C + 2;

   logic signed [LW-1:0] la_s [3];
   logic signed [LW-1:0] lb_s [3];
   logic signed [XW-1:0] lc_s [9];
   logic signed [PW-1:0] pa_s [9][2];
   logic signed [PW-1:0] pb_s [9][2];
   logic signed [RW-1:0] rm_s [3][3];

   logic                 valid_ff;
   logic [LW-2:0]        la_ff [3];
   logic [LW-2:0]        lb_ff [3];
   logic [XW-2:0]        lc_ff [9];
   logic [PW-2:0]        pa_ff [9][2];
   logic [PW-2:0]        pb_ff [9][2];
   logic [RW-2:0]        rm_ff [3][3];
   logic [C-1:0]         ha_ff [3];
   logic [C-1:0]         hb_ff [3];

   // signed dot products, then fold to magnitude in place
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         la_s[i] = LW'(d[0]) * LW'(ua[i][0]) + LW'(d[1]) * LW'(ua[i][1])
                 + LW'(d[2]) * LW'(ua[i][2]);
         lb_s[i] = LW'(d[0]) * LW'(vb[i][0]) + LW'(d[1]) * LW'(vb[i][1])
                 + LW'(d[2]) * LW'(vb[i][2]);
         la_s[i] = la_s[i][LW-1] ? -la_s[i] : la_s[i];
         lb_s[i] = lb_s[i][LW-1] ? -lb_s[i] : lb_s[i];
         for (int k = 0; k < 3; k++) begin
            rm_s[i][k] = rm[i][k][RW-1] ? -rm[i][k] : rm[i][k];
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lc_s[i*3+j] = XW'(d[0]) * XW'(cr[i*3+j][0]) + XW'(d[1]) * XW'(cr[i*3+j][1])
                        + XW'(d[2]) * XW'(cr[i*3+j][2]);
            lc_s[i*3+j] = lc_s[i*3+j][XW-1] ? -lc_s[i*3+j] : lc_s[i*3+j];
            for (int t = 0; t < 2; t++) begin
               pa_s[i*3+j][t] = PW'(cr[i*3+j][0]) * PW'(ua[OTHER[i][t]][0])
                              + PW'(cr[i*3+j][1]) * PW'(ua[OTHER[i][t]][1])
                              + PW'(cr[i*3+j][2]) * PW'(ua[OTHER[i][t]][2]);
               pb_s[i*3+j][t] = PW'(cr[i*3+j][0]) * PW'(vb[OTHER[j][t]][0])
                              + PW'(cr[i*3+j][1]) * PW'(vb[OTHER[j][t]][1])
                              + PW'(cr[i*3+j][2]) * PW'(vb[OTHER[j][t]][2]);
               pa_s[i*3+j][t] = pa_s[i*3+j][t][PW-1] ? -pa_s[i*3+j][t] : pa_s[i*3+j][t];
               pb_s[i*3+j][t] = pb_s[i*3+j][t][PW-1] ? -pb_s[i*3+j][t] : pb_s[i*3+j][t];
            end
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         for (int i = 0; i < 3; i++) begin
            la_ff[i] <= la_s[i][LW-2:0];
            lb_ff[i] <= lb_s[i][LW-2:0];
            ha_ff[i] <= ha_i[i];
            hb_ff[i] <= hb_i[i];
            for (int k = 0; k < 3; k++) begin
               rm_ff[i][k] <= rm_s[i][k][RW-2:0];
            end
         end
         for (int n = 0; n < 9; n++) begin
            lc_ff[n] <= lc_s[n][XW-2:0];
            for (int t = 0; t < 2; t++) begin
               pa_ff[n][t] <= pa_s[n][t][PW-2:0];
               pb_ff[n][t] <= pb_s[n][t][PW-2:0];
            end
         end
      end
   end

   assign out_valid = valid_ff;
   assign la   = la_ff;
   assign lb   = lb_ff;
   assign lc   = lc_ff;
   assign pa   = pa_ff;
   assign pb   = pb_ff;
   assign rabs = rm_ff;
   assign ha_o = ha_ff;
   assign hb_o = hb_ff;
endmodule
`default_nettype wire

>>> src/obb_radius.sv
// Stage three: scaled projected distance and radius sum on all 15 axes.
// Depends on obb_pkg.
`default_nettype none
module obb_radius #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2*COMPONENT_BITS:0]     la   [3],
   input  logic [2*COMPONENT_BITS:0]     lb   [3],
   input  logic [3*COMPONENT_BITS+1:0]   lc   [9],
   input  logic [3*COMPONENT_BITS:0]     pa   [9][2],
   input  logic [3*COMPONENT_BITS:0]     pb   [9][2],
   input  logic [2*COMPONENT_BITS:0]     rabs [3][3],
   input  logic [COMPONENT_BITS-1:0]     ha   [3],
   input  logic [COMPONENT_BITS-1:0]     hb   [3],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [4*COMPONENT_BITS+4:0]   len  [obb_pkg::NUM_AXES],
   output logic [4*COMPONENT_BITS+4:0]   rad  [obb_pkg::NUM_AXES]
);
   import obb_pkg::*;

   localparam int C = COMPONENT_BITS;
   localparam int F = C - 2;
   localparam int W = 4*C + 5;

   logic [W-1:0] len_in [NUM_AXES];
   logic [W-1:0] rad_in [NUM_AXES];
   logic         valid_ff;
   logic [W-1:0] len_ff [NUM_AXES];
   logic [W-1:0] rad_ff [NUM_AXES];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // face axis of box A: own half length plus B's spread
         len_in[i] = W'(la[i]) << F;
         rad_in[i] = (W'(ha[i]) << (2*F))
                   + W'(hb[0]) * W'(rabs[i][0]) + W'(hb[1]) * W'(rabs[i][1])
                   + W'(hb[2]) * W'(rabs[i][2]);
         // face axis of box B
         len_in[3+i] = W'(lb[i]) << F;
         rad_in[3+i] = (W'(hb[i]) << (2*F))
                     + W'(ha[0]) * W'(rabs[0][i]) + W'(ha[1]) * W'(rabs[1][i])
                     + W'(ha[2]) * W'(rabs[2][i]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            len_in[6+i*3+j] = W'(lc[i*3+j]) << F;
            rad_in[6+i*3+j] = W'(ha[OTHER[i][0]]) * W'(pa[i*3+j][0])
                            + W'(ha[OTHER[i][1]]) * W'(pa[i*3+j][1])
                            + W'(hb[OTHER[j][0]]) * W'(pb[i*3+j][0])
                            + W'(hb[OTHER[j][1]]) * W'(pb[i*3+j][1]);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         len_ff <= len_in;
         rad_ff <= rad_in;
      end
   end

   assign out_valid = valid_ff;
   assign len = len_ff;
   assign rad = rad_ff;
endmodule
`default_nettype wire

>>> src/obb_overlap_test.sv
// Oriented box overlap tester, top level: separating axis test on 15 axes.
// Depends on obb_pkg, obb_req_if/obb_rsp_if, obb_prep, obb_proj, obb_radius.
//
// Usage:
//   req_chan carries one box pair per request: centers, three axes and
//   half sizes for box A and box B, each packed x in the low component.
//   rsp_chan returns one bit per request, hit, high when no axis separates
//   the boxes (touching boxes count as a hit). Results keep request order.
// Timing:
//   Four register stages: cross axes and axis dot matrix, projections,
//   radius sums, compare into the output register. An accepted request
//   passes them in that order and then shows on rsp_chan. One request per
//   cycle is accepted for as long as rsp_chan takes results; every stage
//   has its own valid bit, so bubbles are filled.
// Stall:
//   While rsp_chan.ready is low the output register holds its result and
//   the stages behind it keep filling; req_chan.ready drops only when all
//   four stages hold a request.
// Reset:
//   Synchronous, active high; clears all stage valid bits, so no result
//   is shown until a new request has passed through.
`default_nettype none
module obb_overlap_test #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   obb_req_if.sink        req_chan,
   obb_rsp_if.source      rsp_chan
);
   import obb_pkg::*;

   localparam int C = COMPONENT_BITS;
   localparam int W = 4*C + 5;

   field_type              fields [NUM_FIELDS];

   // stage one outputs
   logic                   p1_valid, p1_ready;
   logic signed [C:0]      d    [3];
   logic signed [C-1:0]    ua   [3][3];
   logic signed [C-1:0]    vb   [3][3];
   logic [C-1:0]           ha1  [3];
   logic [C-1:0]           hb1  [3];
   logic signed [2*C:0]    cr   [9][3];
   logic signed [2*C+1:0]  rm   [3][3];

   // stage two outputs
   logic                   p2_valid, p2_ready;
   logic [2*C:0]           la   [3];
   logic [2*C:0]           lb   [3];
   logic [3*C+1:0]         lc   [9];
   logic [3*C:0]           pa   [9][2];
   logic [3*C:0]           pb   [9][2];
   logic [2*C:0]           rabs [3][3];
   logic [C-1:0]           ha2  [3];
   logic [C-1:0]           hb2  [3];

   // stage three outputs
   logic                   p3_valid, p3_ready;
   logic [W-1:0]           len  [NUM_AXES];
   logic [W-1:0]           rad  [NUM_AXES];

   // output register
   logic                   out_ready;
   logic                   hit_in;
   logic                   rsp_valid_ff;
   logic                   hit_ff;

   // pack request fields in their fixed order
   assign fields[0] = req_chan.a_center;
   assign fields[1] = req_chan.a_axis_one;
   assign fields[2] = req_chan.a_axis_two;
   assign fields[3] = req_chan.a_axis_three;
   assign fields[4] = req_chan.a_half_size;
   assign fields[5] = req_chan.b_center;
   assign fields[6] = req_chan.b_axis_one;
   assign fields[7] = req_chan.b_axis_two;
   assign fields[8] = req_chan.b_axis_three;
   assign fields[9] = req_chan.b_half_size;

   obb_prep #(.COMPONENT_BITS(COMPONENT_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .fields    (fields),
      .out_valid (p1_valid),
      .out_ready (p1_ready),
      .d         (d),
      .ua        (ua),
      .vb        (vb),
      .ha        (ha1),
      .hb        (hb1),
      .cr        (cr),
      .rm        (rm)
   );

   obb_proj #(.COMPONENT_BITS(COMPONENT_BITS)) u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p1_valid),
      .in_ready  (p1_ready),
      .d         (d),
      .ua        (ua),
      .vb        (vb),
      .ha_i      (ha1),
      .hb_i      (hb1),
      .cr        (cr),
      .rm        (rm),
      .out_valid (p2_valid),
      .out_ready (p2_ready),
      .la        (la),
      .lb        (lb),
      .lc        (lc),
      .pa        (pa),
      .pb        (pb),
      .rabs      (rabs),
      .ha_o      (ha2),
      .hb_o      (hb2)
   );

   obb_radius #(.COMPONENT_BITS(COMPONENT_BITS)) u_radius (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p2_valid),
      .in_ready  (p2_ready),
      .la        (la),
      .lb        (lb),
      .lc        (lc),
      .pa        (pa),
      .pb        (pb),
      .rabs      (rabs),
      .ha        (ha2),
      .hb        (hb2),
      .out_valid (p3_valid),
      .out_ready (p3_ready),
      .len       (len),
      .rad       (rad)
   );

   // drop the hit as soon as any axis shows a gap wider than the radii
   always_comb begin
      hit_in = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (len[a] > rad[a]) begin
            hit_in = 1'b0;
         end
      end
   end

   // output register advances whenever it is empty or being taken
   assign out_ready = !rsp_valid_ff || rsp_chan.ready;
   assign p3_ready  = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= p3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_valid && out_ready) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit   = hit_ff;

`ifndef SYNTHESIS
   // reset empties the first and last stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !p1_valid))
      else $error("pipeline not empty after reset");

   // an unstalled request reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) ##1 rsp_chan.ready ##1 rsp_chan.ready
         ##1 rsp_chan.ready |=> rsp_chan.valid)
      else $error("request lost on its way through the pipeline");

   // a full last stage behind a stalled output keeps its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (p3_valid && rsp_chan.valid && !rsp_chan.ready) |=> p3_valid)
      else $error("stage three dropped a request during a stall");

   // the request port is blocked only with every stage occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (p1_valid && p2_valid && p3_valid && rsp_chan.valid))
      else $error("request port blocked with a free stage");
`endif
endmodule
`default_nettype wire

>>> sim/obb_overlap_scoreboard.sv
// Box pair overlap predictor and in-order result store for the overlap tester bench.
// Depends on obb_pkg for the field type; used by obb_overlap_test_tb.
package obb_overlap_scoreboard_pkg;
   import obb_pkg::*;

   localparam int CB = 16;
   localparam int AF = CB - 2;

   typedef logic signed [47:0] comp_vec [3];

   class overlap_scoreboard;
      bit pending_hits [$];
      int fail_count;

      function new();
         fail_count = 0;
      endfunction

      static function logic signed [47:0] comp_s(field_type v, int k);
         logic [CB-1:0] raw;
         raw = v[k*CB +: CB];
         return {{(48-CB){raw[CB-1]}}, raw};
      endfunction

      static function logic signed [127:0] dot3(comp_vec a, comp_vec b);
         logic signed [127:0] s;
         s = 0;
         for (int k = 0; k < 3; k++) s += 128'(a[k]) * 128'(b[k]);
         return s;
      endfunction

      static function logic signed [127:0] mag(logic signed [127:0] x);
         return x < 0 ? -x : x;
      endfunction

      // sum over the box axes, skipping one (3 skips none), of half * |axis . e|
      static function logic signed [127:0] box_radius(comp_vec axis, comp_vec e [3],
                                                      logic [CB-1:0] h [3], int skip);
         logic signed [127:0] s;
         s = 0;
         for (int k = 0; k < 3; k++)
            if (k != skip) s += mag(dot3(axis, e[k])) * 128'(h[k]);
         return s;
      endfunction

      static function bit predict_overlap(field_type f [10]);
         comp_vec ua [3], vb [3];
         comp_vec d, c;
         logic [CB-1:0] ha [3], hb [3];
         logic signed [127:0] l, ra, rb;
         bit hit;
         hit = 1;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               ua[i][k] = comp_s(f[1+i], k);
               vb[i][k] = comp_s(f[6+i], k);
            end
            ha[i] = f[4][i*CB +: CB];
            hb[i] = f[9][i*CB +: CB];
            d[i] = comp_s(f[0], i) - comp_s(f[5], i);
         end
         for (int i = 0; i < 3; i++) begin
            l  = mag(dot3(d, ua[i])) <<< AF;
            ra = 128'(ha[i]) <<< (2*AF);
            rb = box_radius(ua[i], vb, hb, 3);
            if (l > ra + rb) hit = 0;
            l  = mag(dot3(d, vb[i])) <<< AF;
            ra = box_radius(vb[i], ua, ha, 3);
            rb = 128'(hb[i]) <<< (2*AF);
            if (l > ra + rb) hit = 0;
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               c[0] = ua[i][1]*vb[j][2] - ua[i][2]*vb[j][1];
               c[1] = ua[i][2]*vb[j][0] - ua[i][0]*vb[j][2];
               c[2] = ua[i][0]*vb[j][1] - ua[i][1]*vb[j][0];
               l  = mag(dot3(d, c)) <<< AF;
               ra = box_radius(c, ua, ha, i);
               rb = box_radius(c, vb, hb, j);
               if (l > ra + rb) hit = 0;
            end
         return hit;
      endfunction

      function void note_request(field_type f [10]);
         pending_hits.push_back(predict_overlap(f));
      endfunction

      function void check_hit(logic actual);
         bit want;
         if (pending_hits.size() == 0) begin
            $error("unexpected response hit=%0b", actual);
            fail_count++;
            return;
         end
         want = pending_hits.pop_front();
         if (actual !== want) begin
            $error("field hit: expected %0b actual %0b", want, actual);
            fail_count++;
         end
      endfunction
   endclass
endpackage

>>> sim/obb_overlap_test_tb.sv
// Top-level bench for obb_overlap_test: directed and random box pairs, random
// idling on both channels, results checked by overlap_scoreboard.
// Depends on obb_pkg, obb_req_if/obb_rsp_if and obb_overlap_scoreboard_pkg.
module obb_overlap_test_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import obb_pkg::*;
   import obb_overlap_scoreboard_pkg::*;

   localparam int RANDOM_REQUESTS = 1730;
   localparam int CYCLE_LIMIT     = 200000;

   logic clock;
   logic reset;
   obb_req_if req_chan ();
   obb_rsp_if rsp_chan ();

   obb_overlap_test #(.COMPONENT_BITS(16)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   overlap_scoreboard board = new();
   int cycle_count = 0;
   bit hold_off_req = 0;     // asks the response sink to hold off for one long stretch
   bit calm_phase = 0;       // no random idling while set

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // count cycles and stop on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // sample responses; drive ready with random idling
   initial begin
      int hold_left;
      rsp_chan.ready = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) board.check_hit(rsp_chan.hit);
         if (hold_off_req && hold_left == 0) begin
            hold_left = 60;
            hold_off_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 38);
         end
      end
   end

   function automatic field_type rand_field();
      return 48'({$urandom, $urandom});
   endfunction

   // unit-ish axis triple: a rotated frame built from sign and permutation
   function automatic void frame_axes(output field_type ax [3]);
      logic [15:0] one;
      int perm;
      one = 16'h4000;
      perm = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
         ax[i] = 0;
         ax[i][((i+perm)%3)*16 +: 16] = $urandom_range(1) ? one : -one;
         // small jitter so cross products are not always exact
         if ($urandom_range(3) == 0)
            ax[i][(((i+perm+1)%3))*16 +: 16] = 16'($signed($urandom_range(800)) - 400);
      end
   endfunction

   function automatic field_type small_centers();
      field_type v;
      v = 0;
      for (int k = 0; k < 3; k++) v[k*16 +: 16] = 16'($signed($urandom_range(1200)) - 600);
      return v;
   endfunction

   function automatic field_type small_halves();
      field_type v;
      v = 0;
      for (int k = 0; k < 3; k++) v[k*16 +: 16] = 16'($urandom_range(400));
      return v;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_pair(field_type f [10]);
      req_chan.valid        <= 1;
      req_chan.a_center     <= f[0];
      req_chan.a_axis_one   <= f[1];
      req_chan.a_axis_two   <= f[2];
      req_chan.a_axis_three <= f[3];
      req_chan.a_half_size  <= f[4];
      req_chan.b_center     <= f[5];
      req_chan.b_axis_one   <= f[6];
      req_chan.b_axis_two   <= f[7];
      req_chan.b_axis_three <= f[8];
      req_chan.b_half_size  <= f[9];
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(f);
      if (!calm_phase && $urandom_range(99) < 38) begin
         req_chan.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 38);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending_hits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // random pair in one of several flavors, mostly well-formed
   function automatic void make_pair(output field_type f [10]);
      field_type ax [3];
      int kind;
      kind = $urandom_range(9);
      if (kind == 0) begin
         // noise: every bit random
         for (int i = 0; i < 10; i++) f[i] = rand_field();
         return;
      end
      f[0] = small_centers();
      f[4] = small_halves();
      frame_axes(ax);
      f[1] = ax[0]; f[2] = ax[1]; f[3] = ax[2];
      f[5] = (kind == 1) ? f[0] : small_centers();
      f[9] = small_halves();
      frame_axes(ax);
      f[6] = ax[0]; f[7] = ax[1]; f[8] = ax[2];
   endfunction

   initial begin
      field_type f [10];
      reset = 1;
      req_chan.valid = 0;
      req_chan.a_center = 0; req_chan.a_axis_one = 0; req_chan.a_axis_two = 0;
      req_chan.a_axis_three = 0; req_chan.a_half_size = 0; req_chan.b_center = 0;
      req_chan.b_axis_one = 0; req_chan.b_axis_two = 0; req_chan.b_axis_three = 0;
      req_chan.b_half_size = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: identity boxes along x, touching, apart and overlapping
      for (int s = 0; s < 4; s++) begin
         f[1] = 48'h0000_0000_4000; f[2] = 48'h0000_4000_0000; f[3] = 48'h4000_0000_0000;
         f[6] = f[1]; f[7] = f[2]; f[8] = f[3];
         f[4] = {16'd64, 16'd64, 16'd64}; f[9] = f[4];
         f[0] = 0;
         // offsets of 1.0, 2.0 (touch), 2.0+lsb (apart), 0
         f[5] = {32'h0, (s == 0) ? 16'd64 : (s == 1) ? 16'd128 : (s == 2) ? 16'd129 : 16'd0};
         send_pair(f);
      end
      // parallel axes: B with x and y axes swapped, cross products of parallel pairs zero
      f[6] = f[2]; f[7] = f[1]; f[8] = f[3]; f[5] = {32'h0, 16'd100};
      send_pair(f);
      // extremes: all zeros, all ones, extreme centers and sizes
      for (int i = 0; i < 10; i++) f[i] = 0;
      send_pair(f);
      for (int i = 0; i < 10; i++) f[i] = '1;
      send_pair(f);
      for (int i = 0; i < 10; i++) f[i] = {16'h8000, 16'h8000, 16'h8000};
      f[5] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_pair(f);
      f[4] = {16'hFFFF, 16'hFFFF, 16'hFFFF}; f[9] = f[4];
      send_pair(f);
      for (int i = 0; i < 10; i++) f[i] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      f[0] = {16'h8000, 16'h8000, 16'h8000};
      send_pair(f);
      for (int i = 0; i < 10; i++) f[i] = {16'h5555, 16'hAAAA, 16'h5555};
      send_pair(f);
      for (int i = 0; i < 10; i++) f[i] = {16'hAAAA, 16'h5555, 16'hAAAA};
      send_pair(f);

      // pause until every expected result has come
      drain();

      // long receiver hold-off while requests keep coming
      calm_phase = 1;
      hold_off_req = 1;
      for (int n = 0; n < 20; n++) begin
         make_pair(f);
         send_pair(f);
      end
      // no idling stretch
      for (int n = 0; n < 150; n++) begin
         make_pair(f);
         send_pair(f);
      end
      calm_phase = 0;
      for (int n = 0; n < RANDOM_REQUESTS - 170; n++) begin
         make_pair(f);
         send_pair(f);
      end
      drain();
      if (board.fail_count == 0 && board.pending_hits.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

>>> obb_overlap_test.f
src/obb_pkg.sv
src/obb_req_if.sv
src/obb_prep.sv
src/obb_proj.sv
src/obb_radius.sv
src/obb_overlap_test.sv
sim/obb_overlap_scoreboard.sv
sim/obb_overlap_test_tb.sv
